@@ hw/rtl/bdpt_pkg.sv @@
package bdpt_pkg;

	typedef enum logic [1:0] {
		PH_RELEASED     = 2'd0,
		PH_PRESS_WAIT   = 2'd1,
		PH_PRESSED      = 2'd2,
		PH_RELEASE_WAIT = 2'd3
	} phase_t;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam int unsigned PADDR_W = 2;
	localparam logic [PADDR_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [15:0] DEBOUNCE_RST = 16'd100;

	typedef struct packed {
		logic        cmd;
		logic        level_pressed;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} stage_t;

endpackage

@@ hw/rtl/bdpt_if.sv @@
interface bdpt_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        level_pressed;
	logic [31:0] now_ms;

	modport source (output valid, cmd, level_pressed, now_ms, input ready);
	modport sink (input valid, cmd, level_pressed, now_ms, output ready);
endinterface

interface bdpt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  fsm_state;
	logic [31:0] press_duration;
	logic        active;

	modport source (output valid, fsm_state, press_duration, active, input ready);
	modport sink (input valid, fsm_state, press_duration, active, output ready);
endinterface

@@ hw/rtl/bdpt_cfg.sv @@
module bdpt_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdpt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [15:0]                 debounce_ms
);
	import bdpt_pkg::*;

	logic [15:0] debounce_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_DEBOUNCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
		end else if (wr_en) begin
			debounce_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_DEBOUNCE) begin
			prdata = {16'd0, debounce_q};
		end
	end

	assign debounce_ms = debounce_q;
endmodule

@@ hw/rtl/bdpt_in_stage.sv @@
module bdpt_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	bdpt_in_if.sink           sample,
	input  logic              take,
	output bdpt_pkg::stage_t  st_s1
);
	import bdpt_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     accept;

	assign sample.ready = !valid_s1 || take;
	assign accept       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd           <= sample.cmd;
			item_s1.level_pressed <= sample.level_pressed;
			item_s1.now_ms        <= sample.now_ms;
		end
	end

	assign st_s1.valid = valid_s1;
	assign st_s1.item  = item_s1;
endmodule

@@ hw/rtl/bdpt_core.sv @@
module bdpt_core (
	input  logic              clk,
	input  logic              arst_n,
	input  bdpt_pkg::stage_t  st_s1,
	input  logic [15:0]       debounce_ms,
	output logic              take,
	bdpt_out_if.source        result
);
	import bdpt_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] stamp_q, stamp_d;
	logic [31:0] deadline_q, deadline_d;
	logic [31:0] held_q, held_d;
	logic        out_valid_q;
	phase_t      out_phase_q;
	logic [31:0] out_dur_q;
	logic [31:0] now;
	logic [31:0] new_deadline;
	logic        timed_out;

	assign take         = st_s1.valid && (!out_valid_q || result.ready);
	assign now          = st_s1.item.now_ms;
	assign new_deadline = now + {16'd0, debounce_ms};
	assign timed_out    = now > deadline_q;

	always_comb begin
		phase_d    = phase_q;
		stamp_d    = stamp_q;
		deadline_d = deadline_q;
		held_d     = held_q;
		if (st_s1.item.cmd == CMD_CLEAR) begin
			held_d = '0;
		end else begin
			case (phase_q)
				PH_RELEASED: begin
					if (st_s1.item.level_pressed) begin
						stamp_d    = now;
						deadline_d = new_deadline;
						phase_d    = PH_PRESS_WAIT;
					end
				end
				PH_PRESS_WAIT: begin
					if (timed_out) begin
						phase_d = PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					if (!st_s1.item.level_pressed) begin
						held_d     = now - stamp_q;
						deadline_d = new_deadline;
						phase_d    = PH_RELEASE_WAIT;
					end
				end
				PH_RELEASE_WAIT: begin
					if (timed_out) begin
						phase_d = PH_RELEASED;
					end
				end
				default: begin
					phase_d = PH_RELEASED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RELEASED;
			stamp_q    <= '0;
			deadline_q <= '0;
			held_q     <= '0;
		end else if (take) begin
			phase_q    <= phase_d;
			stamp_q    <= stamp_d;
			deadline_q <= deadline_d;
			held_q     <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_phase_q <= phase_d;
			out_dur_q   <= held_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.fsm_state      = out_phase_q;
	assign result.press_duration = out_dur_q;
	assign result.active         = (out_phase_q != PH_RELEASED);
endmodule

@@ hw/rtl/button_debounce_press_timer_core.sv @@
// Button debouncer with press-duration timer. Each item is either a sample
// (cmd 0: raw level plus millisecond time stamp) or a clear of the stored
// duration (cmd 1), and each item yields one result holding the debounce
// state, the last press duration and an active flag. An item taken is held in
// the input register until the state update takes it, which happens once the
// output register is empty or its result is being accepted; the update then
// writes the new state and result into the output register, which offers it. A
// new item is taken every cycle while the result side keeps up; the state
// registers close a loop of a single add, subtract and 32-bit compare. The
// debounce time sits at APB offset 0 (low 16 bits, reset 100 ms) and should be
// written only while no item is in flight.
module button_debounce_press_timer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	bdpt_in_if.sink                     sample,
	bdpt_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdpt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import bdpt_pkg::*;

	stage_t      st_s1;
	logic        take;
	logic [15:0] debounce_ms;

	bdpt_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.debounce_ms (debounce_ms)
	);

	bdpt_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.take   (take),
		.st_s1  (st_s1)
	);

	bdpt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.st_s1       (st_s1),
		.debounce_ms (debounce_ms),
		.take        (take),
		.result      (result)
	);
endmodule

@@ sim/tb_button_debounce_press_timer_core.sv @@
`timescale 1ns / 100ps

module tb_button_debounce_press_timer_core;
	import bdpt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500_000;
	localparam int unsigned ITEMS_PER_SETTING = 205;

	typedef struct packed {
		phase_t      fsm_state;
		logic [31:0] press_duration;
		logic        active;
	} status_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bdpt_in_if  sample_if ();
	bdpt_out_if result_if ();

	button_debounce_press_timer_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// debouncer prediction state
	logic [15:0] debounce_cfg   = DEBOUNCE_RST;
	phase_t      debounce_phase = PH_RELEASED;
	logic [31:0] press_stamp_ms = '0;
	logic [31:0] deadline_ms    = '0;
	logic [31:0] held_ms        = '0;

	in_item_t button_samples [$];
	status_t  expected_status [$];

	// button stream generator
	logic [31:0] sim_ms    = '0;
	logic        btn_level = 1'b0;
	int unsigned btn_left  = 0;

	int unsigned cycle_count   = 0;
	int unsigned mismatches    = 0;
	int unsigned items_taken   = 0;
	int unsigned clears_taken  = 0;
	int unsigned results_seen  = 0;
	int unsigned drains        = 0;
	int unsigned settings_used = 1;
	int unsigned state_hits [4] = '{0, 0, 0, 0};

	// sender pacing
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	logic        drain_hold = 1'b0;

	// receiver pacing
	rx_mode_t    stall_mode = RX_OPEN;
	int unsigned stall_span = 0;
	logic [1:0]  stall_tick = '0;

	function automatic void advance_debouncer(in_item_t it);
		status_t st;
		if (it.cmd == CMD_CLEAR) begin
			held_ms = '0;
		end else begin
			case (debounce_phase)
				PH_RELEASED: if (it.level_pressed) begin
					press_stamp_ms = it.now_ms;
					deadline_ms    = it.now_ms + {16'd0, debounce_cfg};
					debounce_phase = PH_PRESS_WAIT;
				end
				PH_PRESS_WAIT: if (it.now_ms > deadline_ms) begin
					debounce_phase = PH_PRESSED;
				end
				PH_PRESSED: if (!it.level_pressed) begin
					held_ms        = it.now_ms - press_stamp_ms;
					deadline_ms    = it.now_ms + {16'd0, debounce_cfg};
					debounce_phase = PH_RELEASE_WAIT;
				end
				default: if (it.now_ms > deadline_ms) begin
					debounce_phase = PH_RELEASED;
				end
			endcase
		end
		st.fsm_state      = debounce_phase;
		st.press_duration = held_ms;
		st.active         = (debounce_phase != PH_RELEASED);
		expected_status.push_back(st);
	endfunction

	function automatic void queue_sample(logic cmd, logic lvl, logic [31:0] t);
		in_item_t it;
		it.cmd           = cmd;
		it.level_pressed = lvl;
		it.now_ms        = t;
		button_samples.push_back(it);
	endfunction

	// mostly a bouncing button on a forward-running clock, plus noise and clears
	function automatic in_item_t next_button_item(logic [15:0] deb);
		in_item_t    it;
		int unsigned span;
		int unsigned roll;
		span = deb + deb / 2 + 2;
		roll = $urandom_range(0, 99);
		it.cmd = CMD_SAMPLE;
		if (roll < 5) begin
			it.cmd           = CMD_CLEAR;
			it.level_pressed = 1'($urandom_range(0, 1));
			it.now_ms        = $urandom();
		end else if (roll < 13) begin
			it.level_pressed = 1'($urandom_range(0, 1));
			it.now_ms        = $urandom();
		end else begin
			if (roll < 16)
				sim_ms = ($urandom_range(0, 1) != 0) ? $urandom() :
					32'hFFFF_FFFF - $urandom_range(0, span);
			else if ($urandom_range(0, 3) == 0)
				sim_ms = sim_ms + $urandom_range(0, span);
			else
				sim_ms = sim_ms + $urandom_range(0, span / 8);
			if (btn_left == 0) begin
				btn_level = !btn_level;
				btn_left  = $urandom_range(1, 10);
			end else begin
				btn_left--;
			end
			it.level_pressed = btn_level ^ ($urandom_range(0, 5) == 0);
			it.now_ms        = sim_ms;
		end
		return it;
	endfunction

	task automatic wait_idle();
		while (button_samples.size() != 0 || expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_debounce(logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_DEBOUNCE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		debounce_cfg = value[15:0];
		settings_used++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_button_debounce_press_timer_core NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin : drive_items
		bit took;
		took = sample_if.valid && sample_if.ready;
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
		end else begin
			if (took) begin
				if (button_samples[0].cmd == CMD_CLEAR)
					clears_taken++;
				advance_debouncer(button_samples.pop_front());
				items_taken++;
			end
			if (!sample_if.valid || took) begin
				if (gap_left != 0) begin
					gap_left        <= gap_left - 1;
					sample_if.valid <= 1'b0;
				end else if (drain_hold && expected_status.size() != 0) begin
					sample_if.valid <= 1'b0;
				end else if (button_samples.size() == 0) begin
					sample_if.valid <= 1'b0;
				end else begin
					sample_if.valid         <= 1'b1;
					sample_if.cmd           <= button_samples[0].cmd;
					sample_if.level_pressed <= button_samples[0].level_pressed;
					sample_if.now_ms        <= button_samples[0].now_ms;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
						if (drains == 0 || $urandom_range(0, 24) == 0) begin
							drain_hold <= 1'b1;
							drains++;
						end else begin
							drain_hold <= 1'b0;
						end
					end else begin
						burst_left <= burst_left - 1;
						drain_hold <= 1'b0;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		status_t got;
		status_t want;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got.fsm_state      = phase_t'(result_if.fsm_state);
				got.press_duration = result_if.press_duration;
				got.active         = result_if.active;
				if (expected_status.size() == 0) begin
					$error("result with no item pending: fsm_state %0d press_duration %0d",
						got.fsm_state, got.press_duration);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					results_seen++;
					state_hits[want.fsm_state]++;
					if (got.fsm_state != want.fsm_state) begin
						$error("fsm_state: expected %0d, actual %0d", want.fsm_state,
							got.fsm_state);
						mismatches++;
					end
					if (got.press_duration != want.press_duration) begin
						$error("press_duration: expected %0d, actual %0d",
							want.press_duration, got.press_duration);
						mismatches++;
					end
					if (got.active != want.active) begin
						$error("active: expected %0d, actual %0d", want.active, got.active);
						mismatches++;
					end
				end
			end
			stall_tick <= stall_tick + 2'd1;
			if (stall_span == 0) begin
				stall_mode <= rx_mode_t'($urandom_range(0, 3));
				stall_span <= $urandom_range(20, 200);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_mode)
				RX_OPEN:   result_if.ready <= 1'b1;
				RX_COIN:   result_if.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: result_if.ready <= ($urandom_range(0, 4) == 0);
				default:   result_if.ready <= (stall_tick == 2'd3);
			endcase
		end
	end

	initial begin : stimulus
		logic [15:0] settings [$];
		logic [31:0] word;
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		sample_if.valid         = 1'b0;
		sample_if.cmd           = CMD_SAMPLE;
		sample_if.level_pressed = 1'b0;
		sample_if.now_ms        = '0;
		result_if.ready         = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset debounce of 100 ms; deadlines wrap and compares sit on the boundary
		queue_sample(CMD_CLEAR, 1'b1, 32'hFFFF_FFFF);
		queue_sample(CMD_SAMPLE, 1'b0, 32'h0000_0000);
		queue_sample(CMD_SAMPLE, 1'b1, 32'hFFFF_FFC0);
		queue_sample(CMD_CLEAR, 1'b0, 32'h0000_0000);
		queue_sample(CMD_SAMPLE, 1'b0, 32'h0000_0010);
		queue_sample(CMD_SAMPLE, 1'b1, 32'h0000_0024);
		queue_sample(CMD_SAMPLE, 1'b0, 32'h0000_0025);
		queue_sample(CMD_SAMPLE, 1'b1, 32'h0000_0030);
		queue_sample(CMD_CLEAR, 1'b0, 32'h0000_0031);
		queue_sample(CMD_SAMPLE, 1'b0, 32'h7FFF_FFFF);
		queue_sample(CMD_CLEAR, 1'b1, 32'h0000_0000);
		queue_sample(CMD_SAMPLE, 1'b1, 32'h8000_0063);
		queue_sample(CMD_SAMPLE, 1'b1, 32'h8000_0064);
		queue_sample(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF);
		queue_sample(CMD_SAMPLE, 1'b1, 32'd99);
		queue_sample(CMD_SAMPLE, 1'b0, 32'd100);
		queue_sample(CMD_SAMPLE, 1'b0, 32'd0);
		queue_sample(CMD_SAMPLE, 1'b0, 32'hFFFF_FFFF);
		queue_sample(CMD_SAMPLE, 1'b0, 32'd5);
		for (int i = 0; i < ITEMS_PER_SETTING; i++)
			button_samples.push_back(next_button_item(debounce_cfg));
		wait_idle();

		settings.push_back(16'd0);
		settings.push_back(16'hFFFF);
		settings.push_back(16'd1);
		settings.push_back(16'($urandom_range(2, 65534)));
		settings.push_back(16'd300);
		settings.push_back(16'd7);
		foreach (settings[s]) begin
			word       = $urandom();
			word[15:0] = settings[s];
			write_debounce(word);
			for (int i = 0; i < ITEMS_PER_SETTING; i++)
				button_samples.push_back(next_button_item(debounce_cfg));
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("%0d items (%0d clears) over %0d debounce settings, %0d drain pauses",
			items_taken, clears_taken, settings_used, drains);
		$display("%0d results checked; released/press wait/pressed/release wait: %0d/%0d/%0d/%0d",
			results_seen, state_hits[0], state_hits[1], state_hits[2], state_hits[3]);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("tb_button_debounce_press_timer_core OK");
		end else begin
			$display("tb_button_debounce_press_timer_core NOT OK");
		end
		$finish;
	end

endmodule
